[hdl/mnfd_pkg.sv]
// Shared types and constants for the Manchester nibble frame decoder.
// No dependencies; imported by every module of the block.
package mnfd_pkg;

  localparam int unsigned DEF_HEADER_BYTES = 6;
  localparam int unsigned DEF_MAX_BYTES    = 9;

  // Header byte that carries the length code in bits 7:6.
  localparam logic [3:0] LEN_BYTE   = 4'd4;
  // Frame bit plus four data bits.
  localparam logic [2:0] GROUP_BITS = 3'd5;

  // Inverted Manchester pair codes.
  localparam logic [1:0] PAIR_ZERO = 2'b01;
  localparam logic [1:0] PAIR_ONE  = 2'b10;

  // Result status codes.
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_PAIR_ERR  = 2'd1;
  localparam logic [1:0] ST_FRAME_ERR = 2'd2;
  localparam logic [1:0] ST_LEN_ERR   = 2'd3;

  // Length codes from header byte LEN_BYTE.
  localparam logic [1:0] LEN_CODE_NONE  = 2'd0;
  localparam logic [1:0] LEN_CODE_ONE   = 2'd1;
  localparam logic [1:0] LEN_CODE_THREE = 2'd2;
  localparam logic [1:0] LEN_CODE_BAD   = 2'd3;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified raw byte; index 3 is the first pair on the air.
  typedef struct packed {
    logic       first;
    logic [3:0] bits_v;
    logic [3:0] bad_v;
  } item_t;

  // One decoded result.
  typedef struct packed {
    logic [1:0] status;
    logic       is_last;
    logic [3:0] byte_index;
    logic [7:0] data_byte;
  } result_t;

endpackage

[hdl/mnfd_front.sv]
// Front end: accepts raw bytes and splits them into decoded bits and pair errors.
// Depends on mnfd_pkg.
module mnfd_front
  import mnfd_pkg::*;
(
  input  logic       s_valid_i,
  input  logic [7:0] s_data_i,
  input  logic       s_first_i,
  input  logic       q_full_i,
  output logic       s_ready_o,
  output logic       push_o,
  output item_t      item_o
);

  logic [1:0] pair_v [4];

  always_comb begin
    item_o.first = s_first_i;
    for (int p = 0; p < 4; p++) begin
      pair_v[p] = s_data_i[7 - 2 * p -: 2];
      item_o.bits_v[3 - p] = (pair_v[p] == PAIR_ONE);
      item_o.bad_v[3 - p]  = !(pair_v[p] inside {PAIR_ZERO, PAIR_ONE});
    end
  end

  assign s_ready_o = !q_full_i;
  assign push_o    = s_valid_i && !q_full_i;

endmodule

[hdl/mnfd_queue.sv]
// Short FIFO of classified items between front and back end.
// Depends on mnfd_pkg.
module mnfd_queue
  import mnfd_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  push_i,
  input  item_t item_i,
  input  logic  pop_i,
  output logic  full_o,
  output logic  valid_o,
  output item_t item_o
);

  item_t              mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0]  count_q;
  logic               do_pop;

  function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] ptr);
    if (ptr == QPTR_W'(QUEUE_DEPTH - 1)) begin
      return '0;
    end
    return ptr + 1'b1;
  endfunction

  assign full_o  = (count_q == QCNT_W'(QUEUE_DEPTH));
  assign valid_o = (count_q != '0);
  assign item_o  = mem_q[rd_ptr_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= item_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (do_pop) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (!push_i && do_pop) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[hdl/mnfd_back.sv]
// Back end: packet state machine over classified items, with output register.
// Depends on mnfd_pkg.
module mnfd_back
  import mnfd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int unsigned MAX_BYTES    = DEF_MAX_BYTES
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic [2:0] skip_bits_i,
  input  logic       q_valid_i,
  input  item_t      q_item_i,
  output logic       q_pop_o,
  output logic       m_valid_o,
  input  logic       m_ready_i,
  output result_t    m_result_o
);

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_RUN,
    PH_DONE
  } phase_e;

  localparam logic [4:0] HDR_LEN = 5'(HEADER_BYTES);
  localparam logic [4:0] MAX_LEN = 5'(MAX_BYTES);
  // A packet never runs past the larger of the header and the maximum.
  localparam logic [4:0] LEN_CAP = (MAX_LEN > HDR_LEN) ? MAX_LEN : HDR_LEN;

  phase_e     phase_q, phase_d;
  logic [2:0] skip_left_q, skip_left_d;
  logic [2:0] group_pos_q, group_pos_d;
  logic [7:0] byte_shift_q, byte_shift_d;
  logic       nibble_sel_q, nibble_sel_d;
  logic [3:0] bytes_done_q, bytes_done_d;
  logic [3:0] target_len_q, target_len_d;
  logic       pair_error_q, pair_error_d;
  logic       frame_error_q, frame_error_d;
  logic       len_bad_q, len_bad_d;

  logic       out_valid_q;
  result_t    out_q;
  logic       emit;
  result_t    res;
  logic       go;

  logic       bit_v;
  logic [1:0] gp_m1;
  logic [4:0] n_v;
  logic [1:0] code_v;
  logic [4:0] tlen_v;
  logic [1:0] extra_v;
  logic       last_v;
  logic [1:0] st_v;

  assign go        = q_valid_i && (!out_valid_q || m_ready_i);
  assign q_pop_o   = go;
  assign m_valid_o = out_valid_q;
  assign m_result_o = out_q;

  always_comb begin
    phase_d       = phase_q;
    skip_left_d   = skip_left_q;
    group_pos_d   = group_pos_q;
    byte_shift_d  = byte_shift_q;
    nibble_sel_d  = nibble_sel_q;
    bytes_done_d  = bytes_done_q;
    target_len_d  = target_len_q;
    pair_error_d  = pair_error_q;
    frame_error_d = frame_error_q;
    len_bad_d     = len_bad_q;
    emit    = 1'b0;
    res     = '0;
    bit_v   = 1'b0;
    gp_m1   = '0;
    n_v     = '0;
    code_v  = '0;
    tlen_v  = '0;
    extra_v = '0;
    last_v  = 1'b0;
    st_v    = ST_OK;

    // A start marker drops whatever packet is in progress.
    if (q_item_i.first) begin
      phase_d       = PH_RUN;
      skip_left_d   = skip_bits_i;
      group_pos_d   = '0;
      byte_shift_d  = '0;
      nibble_sel_d  = 1'b0;
      bytes_done_d  = '0;
      target_len_d  = 4'(HEADER_BYTES);
      pair_error_d  = 1'b0;
      frame_error_d = 1'b0;
      len_bad_d     = 1'b0;
    end

    for (int p = 3; p >= 0; p--) begin
      if (phase_d == PH_RUN) begin
        if (skip_left_d != '0) begin
          skip_left_d = skip_left_d - 1'b1;
        end else begin
          bit_v = q_item_i.bits_v[p];
          if (q_item_i.bad_v[p]) begin
            pair_error_d = 1'b1;
          end
          if (group_pos_d == '0) begin
            if (!bit_v) begin
              frame_error_d = 1'b1;
            end
            group_pos_d = 3'd1;
          end else begin
            gp_m1 = 2'(group_pos_d - 3'd1);
            byte_shift_d[{nibble_sel_d, gp_m1}] = bit_v;
            group_pos_d = group_pos_d + 3'd1;
            if (group_pos_d >= GROUP_BITS) begin
              group_pos_d = '0;
              if (nibble_sel_d) begin
                // Byte complete.
                nibble_sel_d = 1'b0;
                n_v = {1'b0, bytes_done_d} + 5'd1;
                if (bytes_done_d == LEN_BYTE) begin
                  code_v = byte_shift_d[7:6];
                  case (code_v)
                    LEN_CODE_NONE:  extra_v = 2'd0;
                    LEN_CODE_ONE:   extra_v = 2'd1;
                    default:        extra_v = 2'd3;
                  endcase
                  tlen_v = HDR_LEN + {3'b000, extra_v};
                  if (tlen_v > MAX_LEN) begin
                    tlen_v = MAX_LEN;
                  end
                  target_len_d = tlen_v[3:0];
                  len_bad_d    = (code_v == LEN_CODE_BAD);
                end
                last_v = 1'b0;
                st_v   = ST_OK;
                if (n_v >= HDR_LEN &&
                    (n_v == HDR_LEN || n_v >= {1'b0, target_len_d})) begin
                  if (pair_error_d) begin
                    last_v = 1'b1;
                    st_v   = ST_PAIR_ERR;
                  end else if (frame_error_d) begin
                    last_v = 1'b1;
                    st_v   = ST_FRAME_ERR;
                  end else if (n_v == HDR_LEN && len_bad_d) begin
                    last_v = 1'b1;
                    st_v   = ST_LEN_ERR;
                  end else if (n_v >= {1'b0, target_len_d}) begin
                    last_v = 1'b1;
                    st_v   = ST_OK;
                  end
                end
                emit           = 1'b1;
                res.data_byte  = byte_shift_d;
                res.byte_index = bytes_done_d;
                res.is_last    = last_v;
                res.status     = st_v;
                bytes_done_d   = n_v[3:0];
                if (last_v) begin
                  phase_d = PH_DONE;
                end
              end else begin
                nibble_sel_d = 1'b1;
              end
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q       <= PH_IDLE;
      skip_left_q   <= '0;
      group_pos_q   <= '0;
      byte_shift_q  <= '0;
      nibble_sel_q  <= 1'b0;
      bytes_done_q  <= '0;
      target_len_q  <= 4'(HEADER_BYTES);
      pair_error_q  <= 1'b0;
      frame_error_q <= 1'b0;
      len_bad_q     <= 1'b0;
      out_valid_q   <= 1'b0;
      out_q         <= '0;
    end else if (go) begin
      phase_q       <= phase_d;
      skip_left_q   <= skip_left_d;
      group_pos_q   <= group_pos_d;
      byte_shift_q  <= byte_shift_d;
      nibble_sel_q  <= nibble_sel_d;
      bytes_done_q  <= bytes_done_d;
      target_len_q  <= target_len_d;
      pair_error_q  <= pair_error_d;
      frame_error_q <= frame_error_d;
      len_bad_q     <= len_bad_d;
      out_valid_q   <= emit;
      if (emit) begin
        out_q <= res;
      end
    end else if (m_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

`ifndef SYNTHESIS
  a_status_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_q.status != ST_OK |-> out_q.is_last)
    else $error("error status on a byte that is not last");

  a_len_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    {1'b0, bytes_done_q} <= LEN_CAP)
    else $error("byte count beyond packet maximum");

  a_last_ends_packet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    go && emit && res.is_last |=> phase_q == PH_DONE)
    else $error("last byte did not end the packet");
`endif

endmodule

[hdl/manchester_nibble_frame_decoder.sv]
// Top level of the inverted Manchester decoder with nibble framing.
// Depends on mnfd_pkg, mnfd_front, mnfd_queue and mnfd_back.
//
// Usage:
//   s_axis: one received radio byte per transaction, tdata = raw byte
//   (four Manchester pairs, MSB first), tuser = packet start marker.
//   m_axis: one decoded packet byte per transaction; tlast marks the final
//   byte of a packet or of an aborted segment, tdata carries the byte, its
//   index in the packet and the status code.
//   cfg: write channel for skip_bits, always ready; write it only while idle.
// Timing:
//   A completed packet byte raises m_axis_tvalid once the input transaction
//   that completes it has passed the queue and then the output register.
//   One raw byte is taken per cycle sustained while m_axis_tready stays
//   high; the back end handles all four pairs of a byte in one pass.
// Reset:
//   skip_bits returns to 2, the decoder waits for a start marker, the queue
//   and output register empty. Raw bytes without a marker are dropped.
// Stall:
//   When m_axis_tready is low with a result waiting, the output register
//   holds it, the back end stops, and the two-entry queue absorbs input
//   until full, after which s_axis_tready drops.
module manchester_nibble_frame_decoder
  import mnfd_pkg::*;
#(
  parameter int unsigned HEADER_BYTES = DEF_HEADER_BYTES,
  parameter int unsigned MAX_BYTES    = DEF_MAX_BYTES
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  // Input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] raw_byte
  input  logic        s_axis_tuser,   // [0] first
  // Output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] data_byte, [11:8] byte_index,
                                      // [13:12] status, [15:14] zero
  output logic        m_axis_tlast,   // is_last
  // Configuration write channel
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_data_i      // skip_bits
);

  logic       skip_bits_q;
  logic [2:0] skip_bits_r_q;

  logic       q_full, q_valid, q_pop, push;
  item_t      item_in, item_head;
  result_t    result;

  // Configuration register: skip count applied at each packet start.
  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      skip_bits_r_q <= 3'd2;
      skip_bits_q   <= 1'b0;
    end else if (cfg_valid_i) begin
      skip_bits_r_q <= cfg_data_i;
      skip_bits_q   <= 1'b1;
    end
  end

  // Front end: classify each raw byte into decoded bits and pair errors.
  mnfd_front u_front (
    .s_valid_i (s_axis_tvalid),
    .s_data_i  (s_axis_tdata),
    .s_first_i (s_axis_tuser),
    .q_full_i  (q_full),
    .s_ready_o (s_axis_tready),
    .push_o    (push),
    .item_o    (item_in)
  );

  // Queue: decouple the input handshake from the packet state machine.
  mnfd_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .item_i  (item_in),
    .pop_i   (q_pop),
    .full_o  (q_full),
    .valid_o (q_valid),
    .item_o  (item_head)
  );

  // Back end: skip, frame check, byte assembly, length and status.
  mnfd_back #(
    .HEADER_BYTES (HEADER_BYTES),
    .MAX_BYTES    (MAX_BYTES)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .skip_bits_i (skip_bits_r_q),
    .q_valid_i   (q_valid),
    .q_item_i    (item_head),
    .q_pop_o     (q_pop),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_result_o  (result)
  );

  // Pack the result fields, lowest field in the lowest bits.
  assign m_axis_tdata = {2'b00, result.status, result.byte_index, result.data_byte};
  assign m_axis_tlast = result.is_last;

`ifndef SYNTHESIS
  a_cfg_written: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |=> skip_bits_q && skip_bits_r_q == $past(cfg_data_i))
    else $error("configuration write lost");

  a_no_accept_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_full |-> !push)
    else $error("item pushed into a full queue");

  a_pop_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    q_pop |-> q_valid)
    else $error("back end popped an empty queue");
`endif

endmodule

[tb/tb_manchester_nibble_frame_decoder.sv]
// Self-checking testbench for manchester_nibble_frame_decoder.
// Depends on mnfd_pkg and the decoder RTL; a scoreboard class predicts each decoded byte.
// Streams directed and random radio bytes with random idling on both sides.
module tb_manchester_nibble_frame_decoder;
  import mnfd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned HDR_BYTES  = DEF_HEADER_BYTES;
  localparam int unsigned PKT_MAX    = DEF_MAX_BYTES;
  localparam int unsigned RAW_ITEMS  = 500;
  localparam int unsigned SETTLE     = 16;
  localparam int unsigned LONG_HOLD  = 120;
  localparam int unsigned CYCLE_CAP  = 200000;

  // Pair codes that no bit maps to.
  localparam logic [1:0] PAIR_BAD_LOW  = 2'b00;
  localparam logic [1:0] PAIR_BAD_HIGH = 2'b11;

  // Bit-accurate model of the decoder plus the queue of bytes it owes us.
  class frame_scoreboard;
    typedef enum logic [1:0] {DEC_IDLE, DEC_RUN, DEC_DONE} dec_state_e;

    dec_state_e  state;
    logic [2:0]  skip_cfg;
    logic [2:0]  skip_cnt;
    int unsigned grp_pos;
    logic [7:0]  acc_byte;
    logic        upper_nib;
    int unsigned byte_cnt;
    int unsigned pkt_len;
    logic        saw_pair_err;
    logic        saw_frame_err;
    logic        saw_len_err;
    result_t     expected_bytes[$];
    int unsigned fails;

    function new();
      skip_cfg      = 3'd2;
      state         = DEC_IDLE;
      skip_cnt      = '0;
      grp_pos       = 0;
      acc_byte      = '0;
      upper_nib     = 1'b0;
      byte_cnt      = 0;
      pkt_len       = HDR_BYTES;
      saw_pair_err  = 1'b0;
      saw_frame_err = 1'b0;
      saw_len_err   = 1'b0;
      fails         = 0;
    endfunction

    function void set_skip(logic [2:0] v);
      skip_cfg = v;
    endfunction

    // A completed byte: resolve the length code, decide whether it ends the packet.
    function void close_byte();
      int unsigned n;
      int unsigned extra;
      logic        last;
      logic [1:0]  st;
      logic [1:0]  code;
      n    = byte_cnt + 1;
      last = 1'b0;
      st   = ST_OK;
      if (byte_cnt == LEN_BYTE) begin
        code = acc_byte[7:6];
        case (code)
          LEN_CODE_NONE: extra = 0;
          LEN_CODE_ONE:  extra = 1;
          default:       extra = 3;
        endcase
        pkt_len     = (HDR_BYTES + extra > PKT_MAX) ? PKT_MAX : HDR_BYTES + extra;
        saw_len_err = (code == LEN_CODE_BAD);
      end
      // Segment ends at the header boundary if an error was seen by then, else at the packet length.
      if (n >= HDR_BYTES && (n == HDR_BYTES || n >= pkt_len)) begin
        if (saw_pair_err) begin
          last = 1'b1;
          st   = ST_PAIR_ERR;
        end else if (saw_frame_err) begin
          last = 1'b1;
          st   = ST_FRAME_ERR;
        end else if (n == HDR_BYTES && saw_len_err) begin
          last = 1'b1;
          st   = ST_LEN_ERR;
        end else if (n >= pkt_len) begin
          last = 1'b1;
        end
      end
      expected_bytes.push_back('{status: st, is_last: last,
                                 byte_index: byte_cnt[3:0], data_byte: acc_byte});
      byte_cnt = n & 15;
      if (last) state = DEC_DONE;
    endfunction

    // Feed one accepted raw byte through the model.
    function void decode_raw_byte(logic [7:0] raw, logic first);
      logic [1:0]  pr;
      logic        bit_v;
      int unsigned pos;
      if (first) begin
        state         = DEC_RUN;
        skip_cnt      = skip_cfg;
        grp_pos       = 0;
        acc_byte      = '0;
        upper_nib     = 1'b0;
        byte_cnt      = 0;
        pkt_len       = HDR_BYTES;
        saw_pair_err  = 1'b0;
        saw_frame_err = 1'b0;
        saw_len_err   = 1'b0;
      end
      if (state != DEC_RUN) return;
      for (int p = 0; p < 4 && state == DEC_RUN; p++) begin
        pr = raw[7 - 2 * p -: 2];
        // Skipped pairs are dropped unchecked.
        if (skip_cnt > 0) begin
          skip_cnt--;
          continue;
        end
        bit_v = (pr == PAIR_ONE);
        if (pr != PAIR_ONE && pr != PAIR_ZERO) saw_pair_err = 1'b1;
        if (grp_pos == 0) begin
          if (!bit_v) saw_frame_err = 1'b1;
          grp_pos = 1;
        end else begin
          pos = (upper_nib ? 4 : 0) + grp_pos - 1;
          acc_byte[pos] = bit_v;
          grp_pos++;
          if (grp_pos >= GROUP_BITS) begin
            grp_pos = 0;
            if (upper_nib) begin
              upper_nib = 1'b0;
              close_byte();
            end else begin
              upper_nib = 1'b1;
            end
          end
        end
      end
    endfunction

    function void compare_field(string name, int unsigned want, int unsigned got);
      if (want != got) begin
        fails++;
        $display("%0t: %s expected 0x%0h actual 0x%0h", $time, name, want, got);
      end
    endfunction

    // Match one output transaction against the oldest owed byte.
    function void check_decoded_byte(logic [15:0] td, logic tl);
      result_t want;
      if (expected_bytes.size() == 0) begin
        fails++;
        $display("%0t: unexpected output expected none actual tdata=0x%0h tlast=%b",
                 $time, td, tl);
        return;
      end
      want = expected_bytes.pop_front();
      compare_field("data_byte", want.data_byte, td[7:0]);
      compare_field("byte_index", want.byte_index, td[11:8]);
      compare_field("status", want.status, td[13:12]);
      compare_field("is_last", want.is_last, tl);
      compare_field("tdata pad", 0, td[15:14]);
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata;
  logic        s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready;
  logic [15:0] m_axis_tdata;
  logic        m_axis_tlast;
  logic        cfg_valid_i;
  logic        cfg_ready_o;
  logic [2:0]  cfg_data_i;

  frame_scoreboard sb = new();

  int unsigned items_sent;
  int unsigned cycle_count;
  logic [2:0]  cur_skip;
  bit          steady;         // no random idling on either side while set
  bit          long_hold_req;  // ask the receiver for one long stall

  manchester_nibble_frame_decoder #(
    .HEADER_BYTES(HDR_BYTES),
    .MAX_BYTES   (PKT_MAX)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tlast (m_axis_tlast),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Mostly back-to-back, sometimes short gaps, rarely a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Monitors: sample both handshakes at the edge where they complete.
  always @(posedge clk_i) begin
    if (rst_ni && s_axis_tvalid && s_axis_tready)
      sb.decode_raw_byte(s_axis_tdata, s_axis_tuser);
    if (rst_ni && m_axis_tvalid && m_axis_tready)
      sb.check_decoded_byte(m_axis_tdata, m_axis_tlast);
  end

  // Hard stop in case the block hangs.
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_CAP) begin
      $display("status: fail");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off when asked.
  initial begin
    int unsigned stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left    = LONG_HOLD;
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 3) == 0)
        stall_left = pick_gap();
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  // Offer one raw byte and hold it until the transaction completes. tvalid stays
  // high after acceptance, so back-to-back items run with no gap in tvalid.
  task automatic send_item(input logic [7:0] raw, input logic first);
    int unsigned gap;
    gap = steady ? 0 : pick_gap();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    s_axis_tuser  <= first;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
  endtask

  // Build one packet on the air: skipped pairs, five-bit groups per nibble,
  // optional injected faults, random padding; optionally cut short.
  task automatic send_packet(input bit truncate, input bit extremes);
    logic [1:0]  pairs[$];
    logic [1:0]  code;
    logic [7:0]  b;
    logic [9:0]  grp;
    int unsigned nbytes;
    int unsigned r;
    int unsigned idx;
    int unsigned keep;
    r = $urandom_range(0, 99);
    if (extremes)   code = LEN_CODE_NONE;
    else if (r < 35) code = LEN_CODE_NONE;
    else if (r < 65) code = LEN_CODE_ONE;
    else if (r < 90) code = LEN_CODE_THREE;
    else            code = LEN_CODE_BAD;
    case (code)
      LEN_CODE_ONE:   nbytes = HDR_BYTES + 1;
      LEN_CODE_THREE: nbytes = HDR_BYTES + 3;
      default:        nbytes = HDR_BYTES;
    endcase
    if (nbytes > PKT_MAX) nbytes = PKT_MAX;
    // Skipped pairs may hold anything, bad codes included.
    for (int i = 0; i < cur_skip; i++) pairs.push_back(2'($urandom_range(0, 3)));
    for (int i = 0; i < nbytes; i++) begin
      b = extremes ? (i[0] ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
      if (i == LEN_BYTE) b[7:6] = code;
      grp = {b[7:4], 1'b1, b[3:0], 1'b1};
      for (int k = 0; k < 10; k++) pairs.push_back(grp[k] ? PAIR_ONE : PAIR_ZERO);
    end
    if (!extremes && $urandom_range(0, 99) < 15) begin
      idx = $urandom_range(cur_skip, pairs.size() - 1);
      pairs[idx] = $urandom_range(0, 1) ? PAIR_BAD_LOW : PAIR_BAD_HIGH;
    end
    if (!extremes && $urandom_range(0, 99) < 15) begin
      idx = cur_skip + $urandom_range(0, nbytes - 1) * 10 + $urandom_range(0, 1) * 5;
      pairs[idx] = PAIR_ZERO;
    end
    // Pad the tail of the last raw byte with junk pairs.
    while (pairs.size() % 4 != 0) pairs.push_back(2'($urandom_range(0, 3)));
    keep = truncate ? $urandom_range(1, pairs.size() / 4 - 1) : pairs.size() / 4;
    for (int k = 0; k < keep; k++) begin
      send_item({pairs[4*k], pairs[4*k+1], pairs[4*k+2], pairs[4*k+3]}, k == 0);
    end
    items_sent += keep;
  endtask

  // A short burst of unframed bytes, some carrying a start marker.
  task automatic send_noise();
    repeat ($urandom_range(1, 4))
      send_item(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
  endtask

  // Stop offering, then wait for every owed byte and let the block settle.
  task automatic drain_outputs();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_bytes.size() != 0) @(posedge clk_i);
    repeat (SETTLE) @(posedge clk_i);
  endtask

  task automatic write_skip(input logic [2:0] v);
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= v;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    sb.set_skip(v);
    cur_skip    = v;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    int unsigned phase_no;
    int unsigned r;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_data_i    = '0;
    items_sent    = 0;
    cycle_count   = 0;
    cur_skip      = 3'd2;
    steady        = 1'b0;
    long_hold_req = 1'b0;
    phase_no      = 0;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: bytes with no start are dropped while idle.
    send_item(8'hFF, 1'b0);
    send_item(8'h00, 1'b0);
    // A start of all-bad pairs, then abandoned by a fresh start.
    send_item(8'h00, 1'b1);
    send_item(8'hFF, 1'b0);
    // Clean header-only packet with 0x00/0xFF bytes, default skip.
    send_packet(1'b0, 1'b1);
    // Packet finished: trailing bytes without a start are ignored.
    send_item(8'hFF, 1'b0);

    // Random phases, each under its own skip setting.
    while (items_sent < RAW_ITEMS) begin
      drain_outputs();
      case (phase_no)
        0:       write_skip(3'd0);
        1:       write_skip(3'd7);
        default: write_skip(3'($urandom_range(0, 7)));
      endcase
      steady = (phase_no % 4 == 3);
      // Back the block up: receiver holds off while the sender keeps pushing.
      if (phase_no == 1) begin
        steady        = 1'b1;
        long_hold_req = 1'b1;
      end
      repeat (6) begin
        r = $urandom_range(0, 99);
        if (r < 75)      send_packet(1'b0, 1'b0);
        else if (r < 88) send_packet(1'b1, 1'b0);
        else             send_noise();
      end
      phase_no++;
    end

    steady = 1'b0;
    drain_outputs();
    if (sb.fails == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
